// ===== rtl/core/scs_pkg.sv =====
// shared types and constants of the source comment stripper
package scs_pkg;

   localparam int LINE_COUNT_BITS_DEF = 24;

   // characters that steer the scanner
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_SLASH = 8'd47;

   // result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // end-of-text status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_STRAY    = 2'd1;
   localparam logic [1:0] STATUS_UNCLOSED = 2'd2;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_STAR   = 3'd2,
      MODE_LINE   = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_BSTAR  = 3'd5,
      MODE_LIT    = 3'd6
   } scs_mode_type;

   // one result word without its line count
   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last;
   } scs_word_type;

   // results produced by one input word, in delivery order
   typedef struct packed {
      logic [1:0]   count;
      scs_word_type word0;
      scs_word_type word1;
   } scs_step_type;

endpackage

// ===== rtl/core/scs_req_if.sv =====
// input channel: one source byte or an end-of-text mark per word
interface scs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== rtl/core/scs_rsp_if.sv =====
// result channel: kept bytes and end-of-text status reports
interface scs_rsp_if #(
   parameter int LINE_COUNT_BITS = scs_pkg::LINE_COUNT_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [7:0]                 out_byte;
   logic [1:0]                 status;
   logic [LINE_COUNT_BITS-1:0] line_total;
   logic                       last;

   modport source (output valid, output kind, output out_byte, output status,
                   output line_total, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input status,
                   input line_total, input last, output ready);
endinterface

// ===== rtl/core/scs_scan.sv =====
// scanner state machine: mode, line counter and error flags
module scs_scan #(
   parameter int LINE_COUNT_BITS = scs_pkg::LINE_COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [7:0]                 in_byte,
   input  logic                       end_of_input,
   output scs_pkg::scs_step_type      step,
   output logic [LINE_COUNT_BITS-1:0] line0,
   output logic [LINE_COUNT_BITS-1:0] line1
);
   import scs_pkg::*;

   localparam logic [LINE_COUNT_BITS-1:0] COUNT_MAX = '1;

   scs_mode_type               mode_ff, mode_in;
   logic [LINE_COUNT_BITS-1:0] cnt_ff, cnt_in, cnt_inc;
   logic                       stray_ff, stray_in;
   logic                       has_ff, has_in;

   // normal-text handling of the current byte
   scs_mode_type nb_mode;
   logic         nb_bump, nb_emit;

   logic         bump, pend_emit, byte_emit;
   logic [7:0]   pend_byte;
   logic [1:0]   rep_status;
   scs_word_type pend_word, byte_word, rep_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         cnt_ff   <= '0;
         stray_ff <= 1'b0;
         has_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         stray_ff <= stray_in;
         has_ff   <= has_in;
      end
   end

   assign cnt_inc = (cnt_ff != COUNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      nb_mode = MODE_NORMAL;
      nb_bump = 1'b0;
      nb_emit = 1'b0;
      if (in_byte == CH_SLASH) begin
         nb_mode = MODE_SLASH;
      end else if (in_byte == CH_STAR) begin
         nb_mode = MODE_STAR;
      end else if (in_byte == CH_NL) begin
         nb_bump = 1'b1;
      end else begin
         nb_emit = 1'b1;
         if (in_byte == CH_QUOTE) begin
            nb_mode = MODE_LIT;
         end
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      stray_in  = stray_ff;
      has_in    = (in_byte != CH_NL);
      bump      = 1'b0;
      pend_emit = 1'b0;
      pend_byte = CH_SLASH;
      byte_emit = 1'b0;

      unique case (mode_ff)
         MODE_NORMAL: begin
            mode_in   = nb_mode;
            bump      = nb_bump;
            byte_emit = nb_emit;
         end
         MODE_SLASH: begin
            if (in_byte == CH_SLASH) begin
               mode_in = MODE_LINE;
            end else if (in_byte == CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               pend_emit = 1'b1;
               mode_in   = nb_mode;
               bump      = nb_bump;
               byte_emit = nb_emit;
            end
         end
         MODE_STAR: begin
            pend_byte = CH_STAR;
            if (in_byte == CH_SLASH) begin
               stray_in = 1'b1;
               mode_in  = MODE_NORMAL;
            end else if (in_byte == CH_STAR) begin
               pend_emit = 1'b1;
            end else begin
               pend_emit = 1'b1;
               mode_in   = nb_mode;
               bump      = nb_bump;
               byte_emit = nb_emit;
            end
         end
         MODE_LINE: begin
            if (in_byte == CH_NL) begin
               bump    = 1'b1;
               mode_in = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (in_byte == CH_STAR) begin
               mode_in = MODE_BSTAR;
            end else if (in_byte == CH_NL) begin
               bump = 1'b1;
            end
         end
         MODE_BSTAR: begin
            if (in_byte == CH_SLASH) begin
               mode_in = MODE_NORMAL;
            end else if (in_byte != CH_STAR) begin
               bump    = (in_byte == CH_NL);
               mode_in = MODE_BLOCK;
            end
         end
         MODE_LIT: begin
            if (in_byte == CH_NL) begin
               bump    = 1'b1;
               mode_in = MODE_NORMAL;
            end else begin
               byte_emit = 1'b1;
               if (in_byte == CH_QUOTE) begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
         default: begin
            mode_in   = nb_mode;
            bump      = nb_bump;
            byte_emit = nb_emit;
         end
      endcase

      cnt_in = bump ? cnt_inc : cnt_ff;

      // end of text: flush a held slash or star, report, then start over
      if (end_of_input) begin
         pend_emit = (mode_ff == MODE_SLASH) || (mode_ff == MODE_STAR);
         pend_byte = (mode_ff == MODE_STAR) ? CH_STAR : CH_SLASH;
         byte_emit = 1'b0;
         mode_in   = MODE_NORMAL;
         cnt_in    = '0;
         stray_in  = 1'b0;
         has_in    = 1'b0;
      end
   end

   always_comb begin
      if ((mode_ff == MODE_BLOCK) || (mode_ff == MODE_BSTAR)) begin
         rep_status = STATUS_UNCLOSED;
      end else if (stray_ff) begin
         rep_status = STATUS_STRAY;
      end else begin
         rep_status = STATUS_OK;
      end
   end

   assign pend_word = '{kind: KIND_BYTE, out_byte: pend_byte, status: STATUS_OK, last: 1'b0};
   assign byte_word = '{kind: KIND_BYTE, out_byte: in_byte, status: STATUS_OK, last: 1'b1};
   assign rep_word  = '{kind: KIND_REPORT, out_byte: 8'd0, status: rep_status, last: 1'b1};

   // pack results in order; the final one carries last
   always_comb begin
      step.word1 = end_of_input ? rep_word : byte_word;
      line0      = cnt_ff;
      line1      = cnt_ff;
      if (end_of_input && has_ff) begin
         line1 = cnt_inc;
      end
      if (pend_emit && (end_of_input || byte_emit)) begin
         step.count = 2'd2;
         step.word0 = pend_word;
      end else if (pend_emit) begin
         step.count      = 2'd1;
         step.word0      = pend_word;
         step.word0.last = 1'b1;
      end else if (end_of_input || byte_emit) begin
         step.count = 2'd1;
         step.word0 = step.word1;
         line0      = line1;
      end else begin
         step.count = 2'd0;
         step.word0 = byte_word;
      end
   end

endmodule

// ===== rtl/core/scs_rsp_queue.sv =====
// two-entry result queue that takes up to two words at once
module scs_rsp_queue #(
   parameter int DATA_BITS = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  logic [DATA_BITS-1:0] push_data0,
   input  logic [DATA_BITS-1:0] push_data1,
   output logic [1:0]           free_slots,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic [DATA_BITS-1:0] out_data
);
   localparam int DEPTH = 2;

   logic [DATA_BITS-1:0] ent_ff [DEPTH];
   logic                 head_ff, head_in;
   logic [1:0]           count_ff, count_in;
   logic                 tail, pop;

   assign out_valid  = (count_ff != 2'd0);
   assign out_data   = ent_ff[head_ff];
   assign pop        = out_valid && out_ready;
   assign tail       = head_ff ^ count_ff[0];
   assign free_slots = 2'(3'(DEPTH) - {1'b0, count_ff} + {2'b00, pop});
   assign head_in    = head_ff ^ pop;
   assign count_in   = count_ff - {1'b0, pop} + push_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         ent_ff[tail] <= push_data0;
      end
      if (push_count == 2'd2) begin
         ent_ff[~tail] <= push_data1;
      end
   end

endmodule

// ===== rtl/core/source_comment_stripper.sv =====
// top level of the source comment stripper
//
// usage:
//   req_ch carries one source byte per word (in_byte, newline is 10), or an
//   end-of-text mark (end_of_input = 1, in_byte ignored).
//   rsp_ch returns the kept bytes (kind 0) with comments and newlines removed;
//   an end-of-text mark yields any held slash or star and then a status
//   report (kind 1): 0 correct, 1 stray comment close, 2 unclosed block
//   comment. line_total carries the saturating line count, last flags the
//   final result of each input word.
// path: a word accepted on req_ch is held in the input register, is scanned
//   once all its results fit in the queue, and its first result is offered on
//   rsp_ch from the result queue once it has been written there.
// throughput: one input word per cycle while each gives at most one result and
//   rsp_ch.ready stays high; a word that gives two results (held slash or star
//   flushed ahead of the byte or the report) takes two output slots, so it holds
//   back a later word. the limit is the two-entry result queue behind the scanner.
// stall: when rsp_ch.ready is low the queue fills, the scanner holds its
//   word and req_ch.ready drops; nothing is lost or repeated.
// reset: synchronous; clears the mode, line count, error flag, input
//   register and queue. each end-of-text mark also starts a fresh text.
module source_comment_stripper #(
   parameter int LINE_COUNT_BITS = scs_pkg::LINE_COUNT_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   scs_req_if.sink   req_ch,
   scs_rsp_if.source rsp_ch
);
   import scs_pkg::*;

   localparam int DATA_BITS = $bits(scs_word_type) + LINE_COUNT_BITS;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       eoi_ff;

   scs_step_type               step;
   logic [LINE_COUNT_BITS-1:0] line0, line1;
   logic [1:0]                 free_slots;
   logic                       fire;
   logic                       req_take;
   logic [1:0]                 push_count;
   logic [DATA_BITS-1:0]       push_data0, push_data1, q_data;
   scs_word_type               out_word;
   logic [LINE_COUNT_BITS-1:0] out_line;

   // scan a word only when all its results fit in the queue
   assign fire         = in_valid_ff && (step.count <= free_slots);
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.in_byte;
         eoi_ff     <= req_ch.end_of_input;
      end
   end

   scs_scan #(
      .LINE_COUNT_BITS(LINE_COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .in_byte     (in_byte_ff),
      .end_of_input(eoi_ff),
      .step        (step),
      .line0       (line0),
      .line1       (line1)
   );

   assign push_count = fire ? step.count : 2'd0;
   assign push_data0 = {step.word0, line0};
   assign push_data1 = {step.word1, line1};

   scs_rsp_queue #(
      .DATA_BITS(DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_count(push_count),
      .push_data0(push_data0),
      .push_data1(push_data1),
      .free_slots(free_slots),
      .out_ready (rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_data  (q_data)
   );

   assign {out_word, out_line} = q_data;
   assign rsp_ch.kind       = out_word.kind;
   assign rsp_ch.out_byte   = out_word.out_byte;
   assign rsp_ch.status     = out_word.status;
   assign rsp_ch.last       = out_word.last;
   assign rsp_ch.line_total = out_line;

endmodule
